// ----- src/ssps_pkg.sv -----
`default_nettype none

package ssps_pkg;

    localparam int CHANNELS_DEF    = 4;
    localparam int SLOT_COUNTS_DEF = 5000;
    localparam int POS_W           = 10;
    localparam int STEP_W          = 8;
    localparam int CH_W            = 2;
    localparam int OP_W            = 2;
    localparam int INTERVAL_W      = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BASE = 3'd4;

    localparam logic [POS_W-1:0] MAX_LIMIT_RESET = 10'd1023;

    typedef enum logic [OP_W-1:0] {
        OP_SET  = 2'd0,
        OP_SLEW = 2'd1,
        OP_CMP  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLEW,
        ST_CMP
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0]  cur;
        logic [POS_W-1:0]  goal;
        logic [STEP_W-1:0] step;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
        logic              high_edge;
    } alu_in_t;

    typedef struct packed {
        logic [POS_W-1:0]      slew_pos;
        logic [INTERVAL_W-1:0] interval;
    } alu_out_t;

endpackage

`default_nettype wire

// ----- src/ssps_alu.sv -----
`default_nettype none

module ssps_alu
    import ssps_pkg::*;
#(
    parameter int SLOT_COUNTS = SLOT_COUNTS_DEF
) (
    input  alu_in_t  a,
    output alu_out_t y
);

    localparam logic [INTERVAL_W:0] SLOT_EXT = (INTERVAL_W+1)'(SLOT_COUNTS);

    logic [POS_W-1:0]      goal_lo;
    logic [POS_W-1:0]      goal;
    logic [POS_W:0]        goal_plus;
    logic [POS_W:0]        cur_plus;
    logic [POS_W-1:0]      cur_minus;
    logic [INTERVAL_W:0]   pulse;
    logic [INTERVAL_W-1:0] rest;

    always_comb
    begin
        goal_lo   = (a.goal < a.lo) ? a.lo : a.goal;
        goal      = (goal_lo > a.hi) ? a.hi : goal_lo;
        goal_plus = {1'b0, goal} + (POS_W+1)'(a.step);
        cur_plus  = {1'b0, a.cur} + (POS_W+1)'(a.step);
        cur_minus = a.cur - POS_W'(a.step);

        if (a.cur > goal)
        begin
            y.slew_pos = ({1'b0, a.cur} < goal_plus) ? goal : cur_minus;
        end
        else if (a.cur < goal)
        begin
            y.slew_pos = (cur_plus > {1'b0, goal}) ? goal : cur_plus[POS_W-1:0];
        end
        else
        begin
            y.slew_pos = a.cur;
        end

        // times ten as shift and add
        pulse = ((INTERVAL_W+1)'(a.cur) << 3) + ((INTERVAL_W+1)'(a.cur) << 1);
        rest  = (SLOT_EXT > pulse) ? INTERVAL_W'(SLOT_EXT - pulse) : '0;
        y.interval = a.high_edge ? pulse[INTERVAL_W-1:0] : rest;
    end

endmodule

`default_nettype wire

// ----- src/servo_slew_and_pulse_sequencer.sv -----
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | operation, channel, target_angle, step_size
// out     | output    | out_valid/out_ready| out_channel, pin_level, interval_counts,
//         |           |                    | position, last
// cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Set target gives no item. A slew tick gives one item per channel (CHANNELS),
// through a single shared clamp/step unit.
// A compare event gives one item through the same unit.
// A result waits in the output register; each stalled cycle there stalls the walk.
// Reset clears positions, targets, steps, edge phase and slot index; limits reset
// to 0 and 1023.
`default_nettype none

module servo_slew_and_pulse_sequencer
    import ssps_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SLOT_COUNTS = SLOT_COUNTS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [OP_W-1:0]       operation,
    input  wire logic [CH_W-1:0]       channel,
    input  wire logic [POS_W-1:0]      target_angle,
    input  wire logic [STEP_W-1:0]     step_size,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [CH_W-1:0]            out_channel,
    output logic                       pin_level,
    output logic [INTERVAL_W-1:0]      interval_counts,
    output logic [POS_W-1:0]           position,
    output logic                       last,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W:0]    CH_LIMIT = (CH_W+1)'(CHANNELS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

    state_t state_reg, state_next;

    logic [POS_W-1:0]  cur_reg  [CHANNELS];
    logic [POS_W-1:0]  cur_next [CHANNELS];
    logic [POS_W-1:0]  tgt_reg  [CHANNELS];
    logic [POS_W-1:0]  tgt_next [CHANNELS];
    logic [STEP_W-1:0] step_reg [CHANNELS];
    logic [STEP_W-1:0] step_next[CHANNELS];
    logic [POS_W-1:0]  min_reg  [CHANNELS];
    logic [POS_W-1:0]  min_next [CHANNELS];
    logic [POS_W-1:0]  max_reg  [CHANNELS];
    logic [POS_W-1:0]  max_next [CHANNELS];

    logic              edge_reg, edge_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic                  out_valid_reg, out_valid_next;
    logic [CH_W-1:0]       out_ch_reg, out_ch_next;
    logic                  pin_reg, pin_next;
    logic [INTERVAL_W-1:0] intv_reg, intv_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  last_reg, last_next;

    logic [IDX_W-1:0] sel;
    logic             out_free;
    alu_in_t          alu_a;
    alu_out_t         alu_y;

    assign sel      = (state_reg == ST_SLEW) ? idx_reg : slot_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        alu_a.cur       = cur_reg[sel];
        alu_a.goal      = tgt_reg[sel];
        alu_a.step      = step_reg[sel];
        alu_a.lo        = min_reg[sel];
        alu_a.hi        = max_reg[sel];
        alu_a.high_edge = !edge_reg;
    end

    ssps_alu #(
        .SLOT_COUNTS(SLOT_COUNTS)
    ) u_alu (
        .a(alu_a),
        .y(alu_y)
    );

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        tgt_next       = tgt_reg;
        step_next      = step_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        edge_next      = edge_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_ch_next    = out_ch_reg;
        pin_next       = pin_reg;
        intv_next      = intv_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;

        if (cfg_we && ({1'b0, cfg_index[CH_W-1:0]} < CH_LIMIT))
        begin
            if (cfg_index < CFG_MAX_BASE)
            begin
                min_next[cfg_index[IDX_W-1:0]] = cfg_data[POS_W-1:0];
            end
            else
            begin
                max_next[cfg_index[IDX_W-1:0]] = cfg_data[POS_W-1:0];
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (op_t'(operation))
                        OP_SET:
                        begin
                            if ({1'b0, channel} < CH_LIMIT)
                            begin
                                tgt_next[channel[IDX_W-1:0]]  = target_angle;
                                step_next[channel[IDX_W-1:0]] = step_size;
                            end
                        end
                        OP_SLEW:
                        begin
                            idx_next   = '0;
                            state_next = ST_SLEW;
                        end
                        OP_CMP:
                        begin
                            state_next = ST_CMP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SLEW:
            begin
                if (out_free)
                begin
                    cur_next[idx_reg] = alu_y.slew_pos;
                    out_valid_next    = 1'b1;
                    out_ch_next       = CH_W'(idx_reg);
                    pin_next          = 1'b0;
                    intv_next         = '0;
                    pos_next          = alu_y.slew_pos;
                    last_next         = (idx_reg == IDX_LAST);
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_CMP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = CH_W'(slot_reg);
                    pin_next       = !edge_reg;
                    intv_next      = alu_y.interval;
                    pos_next       = cur_reg[slot_reg];
                    last_next      = 1'b1;
                    edge_next      = !edge_reg;
                    if (edge_reg)
                    begin
                        slot_next = (slot_reg == IDX_LAST) ? '0 : slot_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            edge_reg      <= 1'b0;
            slot_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                cur_reg[i]  <= '0;
                tgt_reg[i]  <= '0;
                step_reg[i] <= '0;
                min_reg[i]  <= '0;
                max_reg[i]  <= MAX_LIMIT_RESET;
            end
        end
        else
        begin
            state_reg     <= state_next;
            edge_reg      <= edge_next;
            slot_reg      <= slot_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            tgt_reg       <= tgt_next;
            step_reg      <= step_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_ch_reg <= out_ch_next;
        pin_reg    <= pin_next;
        intv_reg   <= intv_next;
        pos_reg    <= pos_next;
        last_reg   <= last_next;
    end

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign out_channel     = out_ch_reg;
    assign pin_level       = pin_reg;
    assign interval_counts = intv_reg;
    assign position        = pos_reg;
    assign last            = last_reg;

endmodule

`default_nettype wire

// ----- tb/servo_result_checker.sv -----
module servo_result_checker
    import ssps_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SLOT_COUNTS = SLOT_COUNTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [OP_W-1:0]       operation,
    input  logic [CH_W-1:0]       channel,
    input  logic [POS_W-1:0]      target_angle,
    input  logic [STEP_W-1:0]     step_size,

    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [CH_W-1:0]       out_channel,
    input  logic                  pin_level,
    input  logic [INTERVAL_W-1:0] interval_counts,
    input  logic [POS_W-1:0]      position,
    input  logic                  last,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    output int                    mismatches,
    output int                    results_due
);

    localparam int PULSE_SCALE = 10;

    typedef struct packed {
        logic [CH_W-1:0]       chan;
        logic                  pin;
        logic [INTERVAL_W-1:0] interval;
        logic [POS_W-1:0]      pos;
        logic                  last;
    } servo_result_t;

    logic [POS_W-1:0]  lo_limit [4];
    logic [POS_W-1:0]  hi_limit [4];
    logic [POS_W-1:0]  servo_pos [4];
    logic [POS_W-1:0]  servo_goal [4];
    logic [STEP_W-1:0] servo_step [4];
    logic              low_edge_next;
    int                slot;

    servo_result_t servo_results_due [$];

    task automatic report(input string what);
        $display("ERROR: %s", what);
        mismatches++;
    endtask

    function automatic logic [POS_W-1:0] slewed_position(input int i);
        int cur;
        int goal;
        int step;
        cur  = servo_pos[i];
        goal = servo_goal[i];
        step = servo_step[i];
        if (goal < lo_limit[i])
            goal = lo_limit[i];
        if (goal > hi_limit[i])
            goal = hi_limit[i];
        if (cur > goal)
            cur = (cur < goal + step) ? goal : cur - step;
        else if (cur < goal)
            cur = (cur + step > goal) ? goal : cur + step;
        return cur[POS_W-1:0];
    endfunction

    task automatic predict_command();
        servo_result_t r;
        int            pulse;
        case (operation)
            OP_SET:
            begin
                if (channel < CHANNELS)
                begin
                    servo_goal[channel] = target_angle;
                    servo_step[channel] = step_size;
                end
            end
            OP_SLEW:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    servo_pos[i] = slewed_position(i);
                    r.chan       = CH_W'(i);
                    r.pin        = 1'b0;
                    r.interval   = '0;
                    r.pos        = servo_pos[i];
                    r.last       = (i == CHANNELS - 1);
                    servo_results_due.push_back(r);
                end
            end
            OP_CMP:
            begin
                pulse  = servo_pos[slot] * PULSE_SCALE;
                r.chan = CH_W'(slot);
                r.pos  = servo_pos[slot];
                r.last = 1'b1;
                if (!low_edge_next)
                begin
                    r.pin      = 1'b1;
                    r.interval = INTERVAL_W'(pulse);
                end
                else
                begin
                    r.pin      = 1'b0;
                    r.interval = (SLOT_COUNTS > pulse) ? INTERVAL_W'(SLOT_COUNTS - pulse) : '0;
                    slot       = (slot + 1 >= CHANNELS) ? 0 : slot + 1;
                end
                low_edge_next = !low_edge_next;
                servo_results_due.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_result();
        servo_result_t want;
        if (servo_results_due.size() == 0)
        begin
            report($sformatf("result with nothing due: channel %0d pin %0d interval %0d",
                             out_channel, pin_level, interval_counts));
            return;
        end
        want = servo_results_due.pop_front();
        if (out_channel != want.chan)
            report($sformatf("out_channel got %0d want %0d", out_channel, want.chan));
        if (pin_level != want.pin)
            report($sformatf("pin_level got %0d want %0d", pin_level, want.pin));
        if (interval_counts != want.interval)
            report($sformatf("interval_counts got %0d want %0d", interval_counts,
                             want.interval));
        if (position != want.pos)
            report($sformatf("position got %0d want %0d", position, want.pos));
        if (last != want.last)
            report($sformatf("last got %0d want %0d", last, want.last));
    endtask

    initial
    begin
        mismatches  = 0;
        results_due = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                lo_limit[i]   = '0;
                hi_limit[i]   = MAX_LIMIT_RESET;
                servo_pos[i]  = '0;
                servo_goal[i] = '0;
                servo_step[i] = '0;
            end
            low_edge_next = 1'b0;
            slot          = 0;
            servo_results_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index < CFG_MAX_BASE)
                    lo_limit[cfg_index - CFG_MIN_BASE] = cfg_data[POS_W-1:0];
                else
                    hi_limit[cfg_index - CFG_MAX_BASE] = cfg_data[POS_W-1:0];
            end
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                predict_command();
        end
        results_due = servo_results_due.size();
    end

endmodule

// ----- tb/tb_servo_slew_and_pulse_sequencer.sv -----
module tb_servo_slew_and_pulse_sequencer;
    import ssps_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE     = 2'd3;
    localparam int              CYCLE_LIMIT = 600000;
    localparam int              SETTLE      = 20;

    logic                  clk             = 1'b0;
    logic                  rst_n           = 1'b0;
    logic                  in_valid        = 1'b0;
    logic                  in_ready;
    logic [OP_W-1:0]       operation       = '0;
    logic [CH_W-1:0]       channel         = '0;
    logic [POS_W-1:0]      target_angle    = '0;
    logic [STEP_W-1:0]     step_size       = '0;
    logic                  out_valid;
    logic                  out_ready       = 1'b0;
    logic [CH_W-1:0]       out_channel;
    logic                  pin_level;
    logic [INTERVAL_W-1:0] interval_counts;
    logic [POS_W-1:0]      position;
    logic                  last;
    logic                  cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [CFG_DATA_W-1:0] cfg_data        = '0;

    int mismatches;
    int results_due;
    int idle_in_pct   = 0;
    int stall_out_pct = 0;
    int cycle_count   = 0;

    servo_slew_and_pulse_sequencer DUT (.*);

    servo_result_checker checker_i (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= stall_out_pct);

    task automatic send(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                        input logic [POS_W-1:0] ang, input logic [STEP_W-1:0] step);
        @(negedge clk);
        while ($urandom_range(99) < idle_in_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        channel      <= ch;
        target_angle <= ang;
        step_size    <= step;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic program_limits(input logic [3:0][POS_W-1:0] lo,
                                  input logic [3:0][POS_W-1:0] hi);
        for (int i = 0; i < 4; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(CFG_MIN_BASE + i);
            cfg_data  <= lo[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(CFG_MAX_BASE + i);
            cfg_data  <= hi[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random(input int count, input int pause_at);
        int                r;
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  ang;
        logic [STEP_W-1:0] step;
        for (int n = 0; n < count; n++)
        begin
            if (n == pause_at)
                settle();
            r = $urandom_range(99);
            if (r < 35)
                op = OP_SET;
            else if (r < 65)
                op = OP_SLEW;
            else if (r < 95)
                op = OP_CMP;
            else
                op = OP_NONE;
            r = $urandom_range(99);
            if (r < 25)
                ang = $urandom_range(1) ? '1 : '0;
            else
                ang = POS_W'($urandom);
            r = $urandom_range(99);
            if (r < 20)
                step = $urandom_range(1) ? '1 : '0;
            else if (r < 50)
                step = STEP_W'($urandom_range(15, 1));
            else
                step = STEP_W'($urandom);
            send(op, CH_W'($urandom), ang, step);
            if (op == OP_NONE)
                n--;
        end
    endtask

    initial
    begin
        logic [3:0][POS_W-1:0] lo;
        logic [3:0][POS_W-1:0] hi;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        send(OP_SET, 2'd0, 10'd1023, 8'd255);
        send(OP_SET, 2'd1, 10'd0, 8'd1);
        send(OP_SET, 2'd2, 10'd512, 8'd0);
        send(OP_SET, 2'd3, 10'd1023, 8'd7);
        send(OP_SLEW, 2'd0, 10'd0, 8'd0);
        send(OP_SLEW, 2'd3, 10'd1023, 8'd255);
        for (int i = 0; i < 8; i++)
            send(OP_CMP, 2'd0, 10'd0, 8'd0);
        send(OP_NONE, 2'd3, 10'd1023, 8'd255);
        send(OP_SET, 2'd0, 10'd0, 8'd255);
        send(OP_SET, 2'd2, 10'd512, 8'd255);
        send(OP_SET, 2'd3, 10'd10, 8'd200);
        send(OP_SLEW, 2'd1, 10'd0, 8'd0);
        send(OP_SLEW, 2'd2, 10'd0, 8'd0);
        send(OP_SLEW, 2'd0, 10'd0, 8'd0);
        send(OP_CMP, 2'd0, 10'd0, 8'd0);
        send(OP_CMP, 2'd0, 10'd0, 8'd0);
        settle();

        lo = {10'd0, 10'd300, 10'd1023, 10'd100};
        hi = {10'd1023, 10'd200, 10'd0, 10'd900};
        program_limits(lo, hi);
        idle_in_pct   = 10;
        stall_out_pct = 88;
        send_random(120, -1);
        settle();

        lo = {10'd0, POS_W'($urandom), POS_W'($urandom), 10'd1023};
        hi = {POS_W'($urandom), 10'd0, POS_W'($urandom), 10'd1023};
        program_limits(lo, hi);
        idle_in_pct   = 88;
        stall_out_pct = 10;
        send_random(120, 60);
        settle();

        lo = '0;
        hi = '1;
        program_limits(lo, hi);
        idle_in_pct   = 0;
        stall_out_pct = 0;
        send_random(110, -1);
        settle();

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
src/ssps_pkg.sv
src/ssps_alu.sv
src/servo_slew_and_pulse_sequencer.sv
tb/servo_result_checker.sv
tb/tb_servo_slew_and_pulse_sequencer.sv
